// File: rtl/core/br1_pkg.sv
`default_nettype none

package br1_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EMIT
	} st_t;

	typedef enum logic [1:0] {
		PH_CONTROL,
		PH_LITERAL,
		PH_REPEAT
	} phase_t;

	localparam logic       REG_ROW_LENGTH = 1'b0;
	localparam logic       REG_COMP_MODE  = 1'b1;

	localparam logic [12:0] ROW_LENGTH_RESET = 13'd2;
	localparam logic [7:0]  COMP_MODE_RESET  = 8'd1;

	localparam logic [7:0] MODE_RAW      = 8'd0;
	localparam logic [7:0] MODE_BYTERUN1 = 8'd1;
	localparam logic [7:0] CTRL_NOP      = 8'h80;

endpackage

`default_nettype wire

// File: rtl/core/br1_sub_unit.sv
`default_nettype none

module br1_sub_unit #(
	parameter int unsigned W = 8
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff,
	output logic         borrow
);

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

`default_nettype wire

// File: rtl/core/byterun1_row_decoder_top.sv
// Each input byte is accepted in the idle state and then decoded in the sequencer's decode state.
// A repeat run of n bytes adds ceil(n/2) emit results, one result per cycle while the output is free.
// Literal and pass-through results show up after the decode cycle, run results after each emit.
// Output backpressure stalls the decode and emit cycles; decode and emit share a single subtractor.
// Asynchronous reset clears the sequencer, the output valid flag, the row and run counters,
// the sticky error, and loads row_length 2 and compression_mode 1.
`default_nettype none

module byterun1_row_decoder_top import br1_pkg::*; #(
	parameter int unsigned MAX_ROW_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  first_byte,
	output logic [7:0]  second_byte,
	output logic [1:0]  byte_count,
	output logic        row_end,
	output logic        last_of_run,
	output logic        error
);

	localparam int unsigned RLW = $clog2(MAX_ROW_BYTES + 1);
	localparam int unsigned CW  = (RLW > 13) ? RLW : 13;
	localparam int unsigned UW  = (RLW > 8) ? RLW : 8;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_ROW_BYTES);

	st_t            state_q, state_d;
	phase_t         phase_q, phase_d;
	logic [12:0]    row_length_q;
	logic [7:0]     mode_q;
	logic [RLW-1:0] row_left_q, row_left_d;
	logic [7:0]     run_left_q, run_left_d;
	logic [7:0]     cnt_q, cnt_d;
	logic           error_latched_q, error_latched_d;
	logic [7:0]     byte_q;

	logic           out_valid_q;
	logic [7:0]     first_q, second_q;
	logic [1:0]     count_q;
	logic           rend_q, last_q, err_q;

	logic           emit;
	logic [7:0]     e_first, e_second;
	logic [1:0]     e_count;
	logic           e_rend, e_last, e_err;

	logic [CW-1:0]  row_len_ext;
	logic [RLW-1:0] row_clamp;
	logic [RLW-1:0] row_eff;
	logic [7:0]     cnt_ctrl;
	logic           out_free;
	logic           take_two;
	logic           fin;

	logic [UW-1:0]  u_a, u_b, u_diff;
	logic           u_borrow;

	br1_sub_unit #(.W(UW)) u_sub (
		.a      (u_a),
		.b      (u_b),
		.diff   (u_diff),
		.borrow (u_borrow)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;

	assign row_len_ext = CW'(row_length_q);
	assign row_clamp   = (row_length_q == 13'd0) ? RLW'(1) :
	                     (row_len_ext > MAX_C) ? RLW'(MAX_ROW_BYTES) : row_len_ext[RLW-1:0];
	assign row_eff     = (row_left_q == '0) ? row_clamp : row_left_q;
	assign cnt_ctrl    = byte_q[7] ? (~byte_q + 8'd2) : (byte_q + 8'd1);
	assign take_two    = (cnt_q >= 8'd2);
	assign fin         = (cnt_q <= 8'd2);

	always_comb begin
		u_a = UW'(row_eff);
		u_b = UW'(1);
		if (state_q == ST_EMIT) begin
			u_a = UW'(cnt_q);
			u_b = take_two ? UW'(2) : UW'(1);
		end else if (mode_q == MODE_BYTERUN1) begin
			case (phase_q)
				PH_LITERAL: begin
					u_a = UW'(row_left_q);
					u_b = UW'(1);
				end
				PH_REPEAT: begin
					u_a = UW'(row_left_q);
					u_b = UW'(run_left_q);
				end
				default: begin
					u_a = UW'(row_eff);
					u_b = UW'(cnt_ctrl);
				end
			endcase
		end
	end

	always_comb begin
		state_d         = state_q;
		phase_d         = phase_q;
		row_left_d      = row_left_q;
		run_left_d      = run_left_q;
		cnt_d           = cnt_q;
		error_latched_d = error_latched_q;
		emit            = 1'b0;
		e_first         = 8'd0;
		e_second        = 8'd0;
		e_count         = 2'd0;
		e_rend          = 1'b0;
		e_last          = 1'b1;
		e_err           = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (out_free) begin
					state_d = ST_IDLE;
					if (error_latched_q) begin
						emit  = 1'b1;
						e_err = 1'b1;
					end else if (mode_q == MODE_RAW) begin
						phase_d    = PH_CONTROL;
						run_left_d = 8'd0;
						row_left_d = u_diff[RLW-1:0];
						emit       = 1'b1;
						e_first    = byte_q;
						e_count    = 2'd1;
						e_rend     = (u_diff[RLW-1:0] == '0);
					end else if (mode_q != MODE_BYTERUN1) begin
						error_latched_d = 1'b1;
						emit            = 1'b1;
						e_err           = 1'b1;
					end else begin
						case (phase_q)
							PH_LITERAL: begin
								row_left_d = u_diff[RLW-1:0];
								run_left_d = run_left_q - 8'd1;
								if (run_left_q == 8'd1) begin
									phase_d = PH_CONTROL;
								end
								emit    = 1'b1;
								e_first = byte_q;
								e_count = 2'd1;
								e_rend  = (u_diff[RLW-1:0] == '0);
							end
							PH_REPEAT: begin
								row_left_d = u_diff[RLW-1:0];
								cnt_d      = run_left_q;
								run_left_d = 8'd0;
								phase_d    = PH_CONTROL;
								state_d    = ST_EMIT;
							end
							default: begin
								phase_d    = PH_CONTROL;
								row_left_d = row_eff;
								if (byte_q != CTRL_NOP) begin
									if (u_borrow) begin
										error_latched_d = 1'b1;
										emit            = 1'b1;
										e_err           = 1'b1;
									end else begin
										run_left_d = cnt_ctrl;
										phase_d    = byte_q[7] ? PH_REPEAT : PH_LITERAL;
									end
								end
							end
						endcase
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit     = 1'b1;
					e_first  = byte_q;
					e_second = take_two ? byte_q : 8'd0;
					e_count  = take_two ? 2'd2 : 2'd1;
					e_last   = fin;
					e_rend   = fin && (row_left_q == '0);
					cnt_d    = u_diff[7:0];
					if (fin) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_CONTROL;
			row_left_q      <= '0;
			run_left_q      <= 8'd0;
			cnt_q           <= 8'd0;
			error_latched_q <= 1'b0;
			row_length_q    <= ROW_LENGTH_RESET;
			mode_q          <= COMP_MODE_RESET;
			out_valid_q     <= 1'b0;
		end else begin
			phase_q         <= phase_d;
			row_left_q      <= row_left_d;
			run_left_q      <= run_left_d;
			cnt_q           <= cnt_d;
			error_latched_q <= error_latched_d;
			if (cfg_valid) begin
				case (cfg_index)
					REG_ROW_LENGTH: row_length_q <= cfg_data;
					REG_COMP_MODE:  mode_q       <= cfg_data[7:0];
					default:        mode_q       <= mode_q;
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_q <= in_byte;
		end
		if (emit) begin
			first_q  <= e_first;
			second_q <= e_second;
			count_q  <= e_count;
			rend_q   <= e_rend;
			last_q   <= e_last;
			err_q    <= e_err;
		end
	end

	assign out_valid   = out_valid_q;
	assign first_byte  = first_q;
	assign second_byte = second_q;
	assign byte_count  = count_q;
	assign row_end     = rend_q;
	assign last_of_run = last_q;
	assign error       = err_q;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while previous byte still in decode");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		error_latched_q |=> error_latched_q)
		else $error("sticky error cleared without reset");

	a_error_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> byte_count == 2'd0 && !row_end && last_of_run)
		else $error("error result carries data or row end");

	a_data_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error |-> byte_count == 2'd1 || byte_count == 2'd2)
		else $error("data result with bad byte count");

	a_row_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_end |-> last_of_run)
		else $error("row end marked on a non-final result");

endmodule

`default_nettype wire

// File: dv/byterun1_row_decoder_checker.sv
module byterun1_row_decoder_checker import br1_pkg::*; #(
	parameter int unsigned MAX_ROW_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  first_byte,
	input  logic [7:0]  second_byte,
	input  logic [1:0]  byte_count,
	input  logic        row_end,
	input  logic        last_of_run,
	input  logic        error,
	output int          fail_count,
	output int          outstanding,
	output int          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] first;
		logic [7:0] second;
		logic [1:0] count;
		logic       ends_row;
		logic       last;
		logic       err;
	} decoded_t;

	decoded_t    decoded_q[$];
	decoded_t    oldest;
	logic [12:0] row_length_r;
	logic [7:0]  mode_r;
	phase_t      phase;
	logic [12:0] row_left;
	logic [7:0]  run_left;
	logic        err_latched;
	int          fails;
	int          seen;

	task automatic push_result(input logic [7:0] b1, input logic [7:0] b2,
			input logic [1:0] cnt, input logic ends_row, input logic last,
			input logic err);
		decoded_t r;
		r.first = b1;
		r.second = b2;
		r.count = cnt;
		r.ends_row = ends_row;
		r.last = last;
		r.err = err;
		decoded_q.push_back(r);
	endtask

	task automatic latch_error();
		err_latched = 1'b1;
		push_result(8'd0, 8'd0, 2'd0, 1'b0, 1'b1, 1'b1);
	endtask

	task automatic start_row();
		if (row_left == 13'd0) begin
			if (row_length_r == 13'd0)
				row_left = 13'd1;
			else if (row_length_r > MAX_ROW_BYTES)
				row_left = 13'(MAX_ROW_BYTES);
			else
				row_left = row_length_r;
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [8:0] n;
		logic [7:0] left;
		if (err_latched) begin
			latch_error();
		end else if (mode_r == MODE_RAW) begin
			phase = PH_CONTROL;
			run_left = 8'd0;
			start_row();
			row_left = row_left - 13'd1;
			push_result(b, 8'd0, 2'd1, row_left == 13'd0, 1'b1, 1'b0);
		end else if (mode_r != MODE_BYTERUN1) begin
			latch_error();
		end else begin
			case (phase)
				PH_LITERAL: begin
					row_left = row_left - 13'd1;
					run_left = run_left - 8'd1;
					if (run_left == 8'd0)
						phase = PH_CONTROL;
					push_result(b, 8'd0, 2'd1, row_left == 13'd0, 1'b1, 1'b0);
				end
				PH_REPEAT: begin
					left = run_left;
					row_left = row_left - 13'(left);
					run_left = 8'd0;
					phase = PH_CONTROL;
					while (left != 8'd0) begin
						if (left >= 8'd2) begin
							left = left - 8'd2;
							push_result(b, b, 2'd2, left == 8'd0 && row_left == 13'd0,
									left == 8'd0, 1'b0);
						end else begin
							left = 8'd0;
							push_result(b, 8'd0, 2'd1, row_left == 13'd0, 1'b1, 1'b0);
						end
					end
				end
				default: begin
					phase = PH_CONTROL;
					start_row();
					if (b != CTRL_NOP) begin
						n = b[7] ? (9'd257 - {1'b0, b}) : ({1'b0, b} + 9'd1);
						if (13'(n) > row_left) begin
							latch_error();
						end else begin
							run_left = n[7:0];
							phase = b[7] ? PH_REPEAT : PH_LITERAL;
						end
					end
				end
			endcase
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decoded_q.delete();
			row_length_r = ROW_LENGTH_RESET;
			mode_r = COMP_MODE_RESET;
			phase = PH_CONTROL;
			row_left = 13'd0;
			run_left = 8'd0;
			err_latched = 1'b0;
			fails = 0;
			seen = 0;
			fail_count <= 0;
			outstanding <= 0;
			checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					$error("Result transfer with no decoded bytes expected.");
					fails++;
				end else begin
					oldest = decoded_q.pop_front();
					check_field("first_byte", oldest.first, first_byte);
					check_field("second_byte", oldest.second, second_byte);
					check_field("byte_count", oldest.count, byte_count);
					check_field("row_end", oldest.ends_row, row_end);
					check_field("last_of_run", oldest.last, last_of_run);
					check_field("error", oldest.err, error);
					seen++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ROW_LENGTH)
					row_length_r = cfg_data;
				else
					mode_r = cfg_data[7:0];
			end
			if (in_valid && in_ready)
				decode_byte(in_byte);
			fail_count <= fails;
			outstanding <= decoded_q.size();
			checked <= seen;
		end
	end

endmodule

// File: dv/byterun1_row_decoder_top_tb.sv
module byterun1_row_decoder_top_tb import br1_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_ROW = 4096;
	localparam int LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_index = REG_ROW_LENGTH;
	logic [12:0] cfg_data = 13'd0;
	logic        in_valid = 1'b0;
	logic [7:0]  in_byte = 8'd0;
	logic        out_ready = 1'b0;
	wire         cfg_ready;
	wire         in_ready;
	wire         out_valid;
	wire  [7:0]  first_byte;
	wire  [7:0]  second_byte;
	wire  [1:0]  byte_count;
	wire         row_end;
	wire         last_of_run;
	wire         error;

	int          fail_count;
	int          outstanding;
	int          checked;
	int          cycles = 0;
	int          sent = 0;
	int          settings = 0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;
	logic [12:0] row_now = ROW_LENGTH_RESET;
	logic [12:0] row_rem = 13'd0;

	byterun1_row_decoder_top #(.MAX_ROW_BYTES(MAX_ROW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.first_byte(first_byte),
		.second_byte(second_byte),
		.byte_count(byte_count),
		.row_end(row_end),
		.last_of_run(last_of_run),
		.error(error)
	);

	byterun1_row_decoder_checker #(.MAX_ROW_BYTES(MAX_ROW)) watch (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.first_byte(first_byte),
		.second_byte(second_byte),
		.byte_count(byte_count),
		.row_end(row_end),
		.last_of_run(last_of_run),
		.error(error),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.checked(checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// The long hold-off lets repeat runs back up until the input stalls.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				for (int c = 0; c < 400; c++)
					@(posedge clk);
				hold_req = 1'b0;
			end
			out_ready <= quiet || ($urandom_range(99, 0) >= 26);
		end
	end

	function automatic logic [12:0] row_span(input logic [12:0] rl);
		if (rl == 13'd0)
			return 13'd1;
		if (rl > MAX_ROW)
			return 13'(MAX_ROW);
		return rl;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		if (!quiet) begin
			while ($urandom_range(99, 0) < 26) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_byte <= b;
		sent++;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic open_row();
		if (row_rem == 13'd0)
			row_rem = row_span(row_now);
	endtask

	task automatic send_raw(input logic [7:0] b);
		open_row();
		row_rem = row_rem - 13'd1;
		send_byte(b);
	endtask

	task automatic send_literal(input int unsigned n);
		open_row();
		send_byte(8'(n - 1));
		repeat (n) begin
			row_rem = row_rem - 13'd1;
			send_byte(8'($urandom));
		end
	endtask

	task automatic send_repeat(input int unsigned n, input logic [7:0] b);
		open_row();
		send_byte(8'(257 - n));
		row_rem = row_rem - 13'(n);
		send_byte(b);
	endtask

	task automatic send_run();
		int unsigned cap;
		int unsigned pick;
		open_row();
		cap = (row_rem > 13'd128) ? 128 : row_rem;
		pick = $urandom_range(99, 0);
		if (pick < 8) begin
			send_byte(CTRL_NOP);
		end else if (pick < 50 || cap < 2) begin
			if ($urandom_range(9, 0) == 0)
				send_literal(cap);
			else
				send_literal($urandom_range((cap < 6) ? cap : 6, 1));
		end else begin
			if ($urandom_range(9, 0) == 0)
				send_repeat(cap, 8'($urandom));
			else
				send_repeat($urandom_range((cap < 12) ? cap : 12, 2), 8'($urandom));
		end
	endtask

	task automatic settle();
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic configure(input logic [12:0] rl, input logic [7:0] mode);
		in_valid <= 1'b0;
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_ROW_LENGTH;
		cfg_data <= rl;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= REG_COMP_MODE;
		cfg_data <= {5'($urandom), mode};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		row_now = rl;
		settings++;
	endtask

	initial begin
		int unsigned phase_no;
		int unsigned goal;
		int unsigned pick;
		logic [12:0] rl;
		logic [7:0]  mode;

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A skip byte at a row boundary still opens the next row.
		open_row();
		send_byte(CTRL_NOP);
		send_literal(2);
		send_repeat(2, 8'hFF);

		configure(13'd0, MODE_BYTERUN1);
		open_row();
		send_byte(CTRL_NOP);
		send_literal(1);

		configure(13'h1FFF, MODE_BYTERUN1);
		send_repeat(128, 8'h00);
		send_repeat(3, 8'hA5);
		open_row();
		send_byte(8'h02);
		row_rem = row_rem - 13'd1;
		send_byte(8'($urandom));
		configure(row_now, MODE_RAW);
		send_raw(8'h00);
		send_raw(8'hFF);
		configure(row_now, MODE_BYTERUN1);
		open_row();
		send_byte(8'hFD);
		configure(row_now, MODE_RAW);
		send_raw(8'h5A);
		configure(13'd3, MODE_BYTERUN1);
		send_repeat(2, 8'h3C);

		phase_no = 0;
		while (sent < 420) begin
			pick = $urandom_range(99, 0);
			if (pick < 10)
				rl = 13'd0;
			else if (pick < 15)
				rl = 13'(MAX_ROW);
			else if (pick < 20)
				rl = 13'($urandom_range(8191, MAX_ROW + 1));
			else if (pick < 30)
				rl = 13'($urandom_range(300, 100));
			else
				rl = 13'($urandom_range(40, 1));
			mode = ($urandom_range(99, 0) < 20 && phase_no != 4) ? MODE_RAW : MODE_BYTERUN1;
			configure(rl, mode);
			quiet = (phase_no == 2);
			if (phase_no == 4)
				hold_req = 1'b1;
			goal = sent + (quiet ? 100 : $urandom_range(60, 25));
			while (sent < goal) begin
				if (mode == MODE_RAW)
					send_raw(8'($urandom));
				else
					send_run();
			end
			phase_no++;
		end
		quiet = 1'b0;

		if ($urandom_range(1, 0) == 0) begin
			configure(13'd3, MODE_BYTERUN1);
			open_row();
			while (row_rem >= 13'd128)
				send_repeat(128, 8'($urandom));
			open_row();
			send_byte(8'h7F);
		end else begin
			configure(row_now, 8'($urandom_range(255, 2)));
			send_byte(8'($urandom));
		end
		repeat (4)
			send_byte(8'($urandom));
		configure(13'($urandom_range(40, 1)), MODE_RAW);
		repeat (4)
			send_byte(8'($urandom));

		in_valid <= 1'b0;
		settle();
		repeat (20)
			@(posedge clk);
		$display("Checked %0d results from %0d input bytes over %0d register settings.",
				checked, sent, settings);
		$display("Covered literal, repeat, skip and pass-through bytes, row wrap and the sticky error.");
		if (fail_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
